// ===== src/weighted_moment_accumulator_core_assert.svh =====
// Assertion macros for the weighted moment accumulator core.
// Used by the top level only; the checks compile away when SYNTH is defined.
`ifndef WEIGHTED_MOMENT_ACCUMULATOR_CORE_ASSERT_SVH
`define WEIGHTED_MOMENT_ACCUMULATOR_CORE_ASSERT_SVH
`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define WMA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("wma check failed");
// Consequent must hold in the cycle after the antecedent.
`define WMA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("wma check failed");
`else
`define WMA_ASSERT_SAME(lbl, ante, cons)
`define WMA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/wma_pkg.sv =====
// Shared types and constants of the weighted moment accumulator.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package wma_pkg;

    localparam int X_W        = 16;
    localparam int W_W        = 16;
    localparam int NF_W       = 32;
    localparam int SUM_W_W    = 40;
    localparam int SUM_WX_W   = 56;
    localparam int SUM_W2_W   = 56;
    localparam int SUM_W2X_W  = 64;
    localparam int SUM_W2X2_W = 64;
    localparam int MEAN_W     = 32;
    localparam int VAR_W      = 32;
    localparam int SIG_W      = 26;
    localparam int CNT_OUT_W  = 20;
    localparam int UNIT_W     = 128;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 112;
    localparam int OUT_USER_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int MUL_STEPS  = 64;
    localparam int DIV_STEPS  = 128;
    localparam int SQRT_STEPS = 32;
    localparam int STEP_CNT_W = 7;

    localparam logic [SIG_W-1:0] SIG_CAP = SIG_W'(999 * 65536);
    localparam logic [63:0] SIG_CAP_SQ = {38'd0, SIG_CAP} * {38'd0, SIG_CAP};
    localparam logic [NF_W-1:0] NF_RESET = 32'h0001_0000;

    localparam logic [CFG_IDX_W-1:0] REG_NORM_FACTOR      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORMALIZE_ENABLE = 2'd1;

    typedef enum logic [1:0] {
        KIND_MUL,
        KIND_DIV,
        KIND_SQRT
    } unit_kind_t;

    typedef enum logic [3:0] {
        OP_MU,
        OP_MM,
        OP_T2,
        OP_T3,
        OP_DEN,
        OP_VAR,
        OP_SIGQ,
        OP_SQRT,
        OP_MEANN,
        OP_NN,
        OP_VN
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROD,
        ST_SQPROD,
        ST_ACCUM,
        ST_DECIDE,
        ST_ISSUE,
        ST_WAIT,
        ST_NEXT,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic prod;
        logic sqprod;
        logic accum;
        logic report_init;
        logic unit_start;
        op_t  op;
        logic write_out;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
        logic zero_sum;
        logic num_pos;
        logic v_zero;
        logic norm_en;
        logic unit_done;
        logic out_free;
    } dp_status_t;

endpackage

// ===== src/wma_iter.sv =====
// Iterative arithmetic unit: shift-add multiply, restoring divide, integer square root.
// One step per cycle; uses wma_pkg for the operation kinds and step counts.
`timescale 1ns / 1ps

module wma_iter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  wma_pkg::unit_kind_t           kind,
    input  logic [wma_pkg::UNIT_W-1:0]    opa,
    input  logic [wma_pkg::UNIT_W-1:0]    opb,
    output logic                          done,
    output logic [wma_pkg::UNIT_W-1:0]    result
);

    localparam int UW = wma_pkg::UNIT_W;
    localparam int CW = wma_pkg::STEP_CNT_W;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    wma_pkg::unit_kind_t kind_reg, kind_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [UW-1:0]       a_reg, a_next;
    logic [UW-1:0]       b_reg, b_next;
    logic [UW-1:0]       q_reg, q_next;
    logic [UW:0]         acc_reg, acc_next;
    logic [UW:0]         rem_sh;
    logic [63:0]         sq_trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        kind_next = kind_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        q_next    = q_reg;
        acc_next  = acc_reg;
        rem_sh    = {acc_reg[UW-1:0], a_reg[UW-1]};
        sq_trial  = acc_reg[63:0] + q_reg[63:0];
        if (start) begin
            busy_next = 1'b1;
            kind_next = kind;
            a_next    = opa;
            b_next    = opb;
            acc_next  = '0;
            q_next    = '0;
            case (kind)
                wma_pkg::KIND_MUL: begin
                    cnt_next = CW'(wma_pkg::MUL_STEPS - 1);
                end
                wma_pkg::KIND_DIV: begin
                    cnt_next = CW'(wma_pkg::DIV_STEPS - 1);
                end
                wma_pkg::KIND_SQRT: begin
                    cnt_next = CW'(wma_pkg::SQRT_STEPS - 1);
                    // The root bit starts at the top even power of four.
                    q_next   = {64'd0, 64'h4000_0000_0000_0000};
                end
                default: begin
                    cnt_next = '0;
                end
            endcase
        end else if (busy_reg) begin
            case (kind_reg)
                wma_pkg::KIND_MUL: begin
                    if (b_reg[0]) begin
                        acc_next = acc_reg + {1'b0, a_reg};
                    end
                    a_next = a_reg << 1;
                    b_next = b_reg >> 1;
                end
                wma_pkg::KIND_DIV: begin
                    a_next = a_reg << 1;
                    if (rem_sh >= {1'b0, b_reg}) begin
                        acc_next = rem_sh - {1'b0, b_reg};
                        q_next   = {q_reg[UW-2:0], 1'b1};
                    end else begin
                        acc_next = rem_sh;
                        q_next   = {q_reg[UW-2:0], 1'b0};
                    end
                end
                wma_pkg::KIND_SQRT: begin
                    if (a_reg[63:0] >= sq_trial) begin
                        a_next   = {64'd0, a_reg[63:0] - sq_trial};
                        acc_next = {65'd0, (acc_reg[63:0] >> 1) + q_reg[63:0]};
                    end else begin
                        acc_next = {65'd0, acc_reg[63:0] >> 1};
                    end
                    q_next = {64'd0, q_reg[63:0] >> 2};
                end
                default: begin
                    acc_next = acc_reg;
                end
            endcase
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            kind_reg <= wma_pkg::KIND_MUL;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            kind_reg <= kind_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        q_reg   <= q_next;
        acc_reg <= acc_next;
    end

    always_comb begin
        case (kind_reg)
            wma_pkg::KIND_MUL:  result = acc_reg[UW-1:0];
            wma_pkg::KIND_DIV:  result = q_reg;
            wma_pkg::KIND_SQRT: result = {64'd0, acc_reg[63:0]};
            default:            result = '0;
        endcase
    end

    assign done = done_reg;

endmodule

// ===== src/wma_ctrl.sv =====
// Controller of the weighted moment accumulator: sequences accumulation and report steps.
// Depends on wma_pkg for states, operation codes and the command/status structs.
`timescale 1ns / 1ps

module wma_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  wma_pkg::dp_status_t status,
    output wma_pkg::dp_cmd_t    cmd
);

    wma_pkg::state_t state_reg, state_next;
    wma_pkg::op_t    op_reg, op_next;

    always_comb begin
        logic after_var;
        logic after_sig;
        state_next = state_reg;
        op_next    = op_reg;
        after_var  = 1'b0;
        after_sig  = 1'b0;
        case (state_reg)
            wma_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = wma_pkg::ST_PROD;
                end
            end
            wma_pkg::ST_PROD: begin
                state_next = wma_pkg::ST_SQPROD;
            end
            wma_pkg::ST_SQPROD: begin
                state_next = wma_pkg::ST_ACCUM;
            end
            wma_pkg::ST_ACCUM: begin
                state_next = status.last ? wma_pkg::ST_DECIDE : wma_pkg::ST_IDLE;
            end
            wma_pkg::ST_DECIDE: begin
                if (status.zero_sum) begin
                    state_next = wma_pkg::ST_OUTPUT;
                end else begin
                    state_next = wma_pkg::ST_ISSUE;
                    op_next    = wma_pkg::OP_MU;
                end
            end
            wma_pkg::ST_ISSUE: begin
                state_next = wma_pkg::ST_WAIT;
            end
            wma_pkg::ST_WAIT: begin
                if (status.unit_done) begin
                    state_next = wma_pkg::ST_NEXT;
                end
            end
            wma_pkg::ST_NEXT: begin
                state_next = wma_pkg::ST_ISSUE;
                case (op_reg)
                    wma_pkg::OP_MU:    op_next = wma_pkg::OP_MM;
                    wma_pkg::OP_MM:    op_next = wma_pkg::OP_T2;
                    wma_pkg::OP_T2:    op_next = wma_pkg::OP_T3;
                    wma_pkg::OP_T3: begin
                        // A numerator that is not positive leaves the variance at zero.
                        if (status.num_pos) begin
                            op_next = wma_pkg::OP_DEN;
                        end else begin
                            after_var = 1'b1;
                        end
                    end
                    wma_pkg::OP_DEN:   op_next = wma_pkg::OP_VAR;
                    wma_pkg::OP_VAR:   after_var = 1'b1;
                    wma_pkg::OP_SIGQ:  op_next = wma_pkg::OP_SQRT;
                    wma_pkg::OP_SQRT:  after_sig = 1'b1;
                    wma_pkg::OP_MEANN: op_next = wma_pkg::OP_NN;
                    wma_pkg::OP_NN:    op_next = wma_pkg::OP_VN;
                    wma_pkg::OP_VN:    state_next = wma_pkg::ST_OUTPUT;
                    default:           state_next = wma_pkg::ST_OUTPUT;
                endcase
                if (after_var) begin
                    if (!status.v_zero) begin
                        op_next = wma_pkg::OP_SIGQ;
                    end else begin
                        after_sig = 1'b1;
                    end
                end
                if (after_sig) begin
                    if (status.norm_en) begin
                        op_next = wma_pkg::OP_MEANN;
                    end else begin
                        state_next = wma_pkg::ST_OUTPUT;
                    end
                end
            end
            wma_pkg::ST_OUTPUT: begin
                if (status.out_free) begin
                    state_next = wma_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wma_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready        = (state_reg == wma_pkg::ST_IDLE);
        cmd.prod        = (state_reg == wma_pkg::ST_PROD);
        cmd.sqprod      = (state_reg == wma_pkg::ST_SQPROD);
        cmd.accum       = (state_reg == wma_pkg::ST_ACCUM);
        cmd.report_init = (state_reg == wma_pkg::ST_DECIDE);
        cmd.unit_start  = (state_reg == wma_pkg::ST_ISSUE);
        cmd.op          = op_reg;
        cmd.write_out   = (state_reg == wma_pkg::ST_OUTPUT) && status.out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wma_pkg::ST_IDLE;
            op_reg    <= wma_pkg::OP_MU;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

endmodule

// ===== src/wma_dp.sv =====
// Datapath of the weighted moment accumulator: sums, report registers, output register.
// Depends on wma_pkg and instantiates the iterative unit wma_iter.
`timescale 1ns / 1ps

module wma_dp #(
    parameter int COUNT_BITS = 20
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [wma_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic                                s_tuser,
    input  logic                                s_tlast,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [wma_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic [wma_pkg::OUT_USER_W-1:0]      m_tuser,
    input  logic                                cfg_valid,
    input  logic [wma_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wma_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wma_pkg::dp_cmd_t                    cmd,
    output wma_pkg::dp_status_t                 status
);

    localparam int UW = wma_pkg::UNIT_W;
    localparam int CO = wma_pkg::CNT_OUT_W;

    // Configuration.
    logic signed [31:0] nf_reg;
    logic               norm_en_reg;

    // Captured request and products.
    logic signed [15:0] x_reg, w_reg;
    logic               first_reg, last_reg;
    logic signed [31:0] wx_reg, ww_reg;
    logic signed [47:0] w2x_reg;
    logic signed [63:0] wx2_reg;

    // Running sums.
    logic signed [39:0] sw_reg;
    logic signed [55:0] swx_reg, sw2_reg;
    logic signed [63:0] s2x_reg, s2x2_reg;
    logic [COUNT_BITS-1:0] cnt_reg;

    // Report registers.
    logic signed [31:0] mu_reg, meann_reg;
    logic [63:0]        mm_reg, v_reg, sigq_reg, nn_reg;
    logic [UW-1:0]      num_reg, den_reg;
    logic               sig_big_reg;
    logic [25:0]        sig_reg;
    logic [31:0]        vn_reg;

    // Output register.
    logic                              m_tvalid_reg;
    logic [wma_pkg::OUT_DATA_W-1:0]    m_tdata_reg;
    logic [wma_pkg::OUT_USER_W-1:0]    m_tuser_reg;

    logic signed [39:0] sw_base;
    logic signed [55:0] swx_base, sw2_base;
    logic signed [63:0] s2x_base, s2x2_base;
    logic signed [40:0] sw_add;
    logic signed [56:0] swx_add, sw2_add;
    logic signed [64:0] s2x_add, s2x2_add;
    logic signed [39:0] sw_sat;
    logic signed [55:0] swx_sat, sw2_sat;
    logic signed [63:0] s2x_sat, s2x2_sat;

    logic [39:0] sw_abs;
    logic [55:0] swx_abs, sw2_abs;
    logic [63:0] s2x_abs, s2x2_abs;
    logic [31:0] mu_abs, nf_abs;

    wma_pkg::unit_kind_t unit_kind;
    logic [UW-1:0]       unit_a, unit_b, unit_res;
    logic                unit_done;

    logic [63:0]         q_lo;
    logic [47:0]         meann_mag;
    logic                mu_neg, meann_neg;
    logic [CO-1:0]       count_out;

    // Saturating accumulation; a first-sample request starts from zero.
    always_comb begin
        sw_base   = cmd.accum && first_reg ? '0 : sw_reg;
        swx_base  = first_reg ? '0 : swx_reg;
        sw2_base  = first_reg ? '0 : sw2_reg;
        s2x_base  = first_reg ? '0 : s2x_reg;
        s2x2_base = first_reg ? '0 : s2x2_reg;
        sw_add    = 41'(sw_base) + 41'(w_reg);
        swx_add   = 57'(swx_base) + 57'(wx_reg);
        sw2_add   = 57'(sw2_base) + 57'(ww_reg);
        s2x_add   = 65'(s2x_base) + 65'(w2x_reg);
        s2x2_add  = 65'(s2x2_base) + 65'(wx2_reg);
        sw_sat    = (sw_add[40] != sw_add[39]) ? {sw_add[40], {39{!sw_add[40]}}}
                                               : sw_add[39:0];
        swx_sat   = (swx_add[56] != swx_add[55]) ? {swx_add[56], {55{!swx_add[56]}}}
                                                 : swx_add[55:0];
        sw2_sat   = (sw2_add[56] != sw2_add[55]) ? {sw2_add[56], {55{!sw2_add[56]}}}
                                                 : sw2_add[55:0];
        s2x_sat   = (s2x_add[64] != s2x_add[63]) ? {s2x_add[64], {63{!s2x_add[64]}}}
                                                 : s2x_add[63:0];
        s2x2_sat  = (s2x2_add[64] != s2x2_add[63]) ? {s2x2_add[64], {63{!s2x2_add[64]}}}
                                                   : s2x2_add[63:0];
    end

    always_comb begin
        sw_abs   = sw_reg[39]   ? 40'd0 - sw_reg   : sw_reg;
        swx_abs  = swx_reg[55]  ? 56'd0 - swx_reg  : swx_reg;
        sw2_abs  = sw2_reg[55]  ? 56'd0 - sw2_reg  : sw2_reg;
        s2x_abs  = s2x_reg[63]  ? 64'd0 - s2x_reg  : s2x_reg;
        s2x2_abs = s2x2_reg[63] ? 64'd0 - s2x2_reg : s2x2_reg;
        mu_abs   = mu_reg[31]   ? 32'd0 - mu_reg   : mu_reg;
        nf_abs   = nf_reg[31]   ? 32'd0 - nf_reg   : nf_reg;
    end

    // Operand selection for the shared iterative unit.
    always_comb begin
        unit_kind = wma_pkg::KIND_MUL;
        unit_a    = '0;
        unit_b    = '0;
        case (cmd.op)
            wma_pkg::OP_MU: begin
                unit_kind = wma_pkg::KIND_DIV;
                unit_a    = {70'd0, swx_abs, 2'b00};
                unit_b    = {88'd0, sw_abs};
            end
            wma_pkg::OP_MM: begin
                unit_a = {96'd0, mu_abs};
                unit_b = {96'd0, mu_abs};
            end
            wma_pkg::OP_T2: begin
                unit_a = {93'd0, mu_abs, 3'b000};
                unit_b = {64'd0, s2x_abs};
            end
            wma_pkg::OP_T3: begin
                unit_a = {64'd0, mm_reg};
                unit_b = {72'd0, sw2_abs};
            end
            wma_pkg::OP_DEN: begin
                unit_a = {88'd0, sw_abs};
                unit_b = {88'd0, sw_abs};
            end
            wma_pkg::OP_VAR: begin
                unit_kind = wma_pkg::KIND_DIV;
                unit_a    = num_reg;
                unit_b    = den_reg;
            end
            wma_pkg::OP_SIGQ: begin
                unit_kind = wma_pkg::KIND_DIV;
                unit_a    = {48'd0, mm_reg, 16'd0};
                unit_b    = {64'd0, v_reg};
            end
            wma_pkg::OP_SQRT: begin
                unit_kind = wma_pkg::KIND_SQRT;
                unit_a    = {64'd0, sigq_reg};
            end
            wma_pkg::OP_MEANN: begin
                unit_a = {96'd0, mu_abs};
                unit_b = {96'd0, nf_abs};
            end
            wma_pkg::OP_NN: begin
                unit_a = {96'd0, nf_abs};
                unit_b = {96'd0, nf_abs};
            end
            wma_pkg::OP_VN: begin
                unit_a = {64'd0, v_reg};
                unit_b = {64'd0, nn_reg};
            end
            default: begin
                unit_kind = wma_pkg::KIND_MUL;
            end
        endcase
    end

    wma_iter u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.unit_start),
        .kind    (unit_kind),
        .opa     (unit_a),
        .opb     (unit_b),
        .done    (unit_done),
        .result  (unit_res)
    );

    always_comb begin
        q_lo      = unit_res[63:0];
        mu_neg    = swx_reg[55] ^ sw_reg[39];
        meann_neg = mu_reg[31] ^ nf_reg[31];
        meann_mag = unit_res[63:16];
    end

    generate
        if (COUNT_BITS > CO) begin : g_cnt_sat
            assign count_out = (|cnt_reg[COUNT_BITS-1:CO]) ? '1 : cnt_reg[CO-1:0];
        end else begin : g_cnt_ext
            assign count_out = CO'(cnt_reg);
        end
    endgenerate

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nf_reg      <= wma_pkg::NF_RESET;
            norm_en_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                wma_pkg::REG_NORM_FACTOR:      nf_reg      <= cfg_data;
                wma_pkg::REG_NORMALIZE_ENABLE: norm_en_reg <= cfg_data[0];
                default: begin
                    nf_reg <= nf_reg;
                end
            endcase
        end
    end

    // Request capture and product pipeline.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            x_reg <= s_tdata[15:0];
            w_reg <= s_tdata[31:16];
        end
        if (cmd.prod) begin
            wx_reg <= 32'(x_reg) * 32'(w_reg);
            ww_reg <= 32'(w_reg) * 32'(w_reg);
        end
        if (cmd.sqprod) begin
            w2x_reg <= 48'(w_reg) * 48'(wx_reg);
            wx2_reg <= 64'(wx_reg) * 64'(wx_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b0;
            last_reg  <= 1'b0;
            sw_reg    <= '0;
            swx_reg   <= '0;
            sw2_reg   <= '0;
            s2x_reg   <= '0;
            s2x2_reg  <= '0;
            cnt_reg   <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                first_reg <= s_tuser;
                last_reg  <= s_tlast;
            end
            if (cmd.accum) begin
                sw_reg   <= sw_sat;
                swx_reg  <= swx_sat;
                sw2_reg  <= sw2_sat;
                s2x_reg  <= s2x_sat;
                s2x2_reg <= s2x2_sat;
                if (first_reg) begin
                    cnt_reg <= COUNT_BITS'(1);
                end else if (cnt_reg != '1) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    // Report registers, set up when a report starts and loaded as each step of the unit finishes.
    always_ff @(posedge aclk) begin
        if (cmd.report_init) begin
            num_reg     <= s2x2_reg[63] ? UW'(0) - {60'd0, s2x2_abs, 4'd0}
                                        : {60'd0, s2x2_abs, 4'd0};
            v_reg       <= '0;
            sig_reg     <= wma_pkg::SIG_CAP;
            sig_big_reg <= 1'b0;
        end else if (unit_done) begin
            case (cmd.op)
                wma_pkg::OP_MU: begin
                    if (!mu_neg) begin
                        mu_reg <= (unit_res > UW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                                  : unit_res[31:0];
                    end else begin
                        mu_reg <= (unit_res > UW'(32'h8000_0000)) ? 32'h8000_0000
                                                                  : 32'd0 - unit_res[31:0];
                    end
                end
                wma_pkg::OP_MM: mm_reg <= q_lo;
                wma_pkg::OP_T2: begin
                    // The middle term subtracts when mu and the sum share a sign.
                    num_reg <= (mu_reg[31] == s2x_reg[63]) ? num_reg - unit_res
                                                           : num_reg + unit_res;
                end
                wma_pkg::OP_T3: begin
                    num_reg <= sw2_reg[55] ? num_reg - unit_res : num_reg + unit_res;
                end
                wma_pkg::OP_DEN: den_reg <= unit_res << 16;
                wma_pkg::OP_VAR: v_reg <= (|unit_res[UW-1:64]) ? '1 : q_lo;
                wma_pkg::OP_SIGQ: begin
                    sigq_reg    <= q_lo;
                    sig_big_reg <= (|unit_res[UW-1:64]) || (q_lo >= wma_pkg::SIG_CAP_SQ);
                end
                wma_pkg::OP_SQRT: begin
                    sig_reg <= (sig_big_reg || q_lo > {38'd0, wma_pkg::SIG_CAP})
                               ? wma_pkg::SIG_CAP : q_lo[25:0];
                end
                wma_pkg::OP_MEANN: begin
                    if (!meann_neg) begin
                        meann_reg <= (meann_mag > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF
                                                                 : meann_mag[31:0];
                    end else begin
                        meann_reg <= (meann_mag > 48'h8000_0000) ? 32'h8000_0000
                                                                 : 32'd0 - meann_mag[31:0];
                    end
                end
                wma_pkg::OP_NN: nn_reg <= q_lo;
                wma_pkg::OP_VN: vn_reg <= (|unit_res[UW-1:64]) ? 32'hFFFF_FFFF
                                                                : unit_res[63:32];
                default: begin
                    nn_reg <= nn_reg;
                end
            endcase
        end
    end

    // Output register; the next request may be accepted while a result waits here.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.write_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_out) begin
            if (sw_reg == '0) begin
                m_tdata_reg <= '0;
                m_tuser_reg <= 2'b10;
            end else begin
                m_tdata_reg[31:0]    <= norm_en_reg ? meann_reg : mu_reg;
                m_tdata_reg[63:32]   <= norm_en_reg ? vn_reg
                                        : ((|v_reg[63:32]) ? 32'hFFFF_FFFF : v_reg[31:0]);
                m_tdata_reg[89:64]   <= sig_reg;
                m_tdata_reg[109:90]  <= count_out;
                m_tdata_reg[111:110] <= 2'b00;
                m_tuser_reg          <= {1'b0, v_reg == '0};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        status.last      = last_reg;
        status.zero_sum  = (sw_reg == '0);
        status.num_pos   = !num_reg[UW-1] && (|num_reg);
        status.v_zero    = (v_reg == '0);
        status.norm_en   = norm_en_reg;
        status.unit_done = unit_done;
        status.out_free  = !m_tvalid_reg || m_tready;
    end

endmodule

// ===== src/weighted_moment_accumulator_core.sv =====
// Weighted moment accumulator: weighted mean with its variance and significance.
// Top level; joins wma_ctrl and wma_dp, uses wma_pkg and the assertion header.
`timescale 1ns / 1ps

// Each request carries a Q2.14 sample and a Q4.12 weight and is folded into five
// saturating sums through capture, two registered product stages and a saturating
// add; no new request is taken until these steps are done. A request marked last
// then starts a report, which runs through a single shared shift-add multiplier,
// restoring divider and square-root unit, one bit per cycle, with issue, wait and
// next states of sequencing around each step. A zero weight sum skips the unit and
// goes straight to the output.
// The result sits in an output register, so a new request is accepted while it waits.
// Configuration writes are always ready and must only be made while the block is idle.
module weighted_moment_accumulator_core #(
    parameter int COUNT_BITS = 20
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [wma_pkg::IN_DATA_W-1:0]      s_tdata,   // value_x, weight
    input  logic                               s_tuser,   // first_sample
    input  logic                               s_tlast,   // last_sample
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // mean_value, variance_value, significance_value, sample_count, 2 pad bits
    output logic [wma_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [wma_pkg::OUT_USER_W-1:0]     m_tuser,   // significance_capped on zero variance, zero_weight_sum
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [wma_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wma_pkg::CFG_DATA_W-1:0]     cfg_data
);

    wma_pkg::dp_cmd_t    cmd;
    wma_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    wma_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    wma_dp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

`include "weighted_moment_accumulator_core_assert.svh"

    // Only one request is in work at a time.
    `WMA_ASSERT_NEXT(a_one_request, s_tvalid && s_tready, !s_tready)
    // A capped significance always reports exactly 999.0.
    `WMA_ASSERT_SAME(a_cap_value, m_tvalid && m_tuser[0], m_tdata[89:64] == wma_pkg::SIG_CAP)
    // A zero weight sum clears every data field.
    `WMA_ASSERT_SAME(a_zero_sum, m_tvalid && m_tuser[1], m_tdata == '0)

endmodule
